/* sv/mpbs_pkg.sv */
package mpbs_pkg;

    localparam int BYTE_W            = 8;
    localparam int MAX_PATTERNS      = 4;
    localparam int MAX_PATTERN_BYTES = 16;
    localparam int PATTERN_W         = MAX_PATTERN_BYTES * BYTE_W;
    localparam int POS_W             = 4;
    localparam int COUNT_W           = 5;
    localparam int CFG_REGS          = 8;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 64;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in;

    typedef struct packed {
        logic [MAX_PATTERNS-1:0] found_mask;
        logic                    scan_done;
    } t_out;

    // step control shared by all matcher lanes
    typedef struct packed {
        logic advance;
        logic last;
    } t_lane_ctl;

    typedef logic [MAX_PATTERNS-1:0][PATTERN_W-1:0] t_patterns;

endpackage

/* sv/mpbs_cfg_regs.sv */
module mpbs_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mpbs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mpbs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output mpbs_pkg::t_patterns                o_patterns
);

    logic [mpbs_pkg::CFG_REGS-1:0][mpbs_pkg::CFG_DATA_W-1:0] r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (i_cfg_we) begin
            r_regs[i_cfg_idx] <= i_cfg_data;
        end
    end

    // low half holds bytes 0..7, high half bytes 8..15
    always_comb begin
        for (int j = 0; j < mpbs_pkg::MAX_PATTERNS; j++) begin
            o_patterns[j] = {r_regs[2*j+1], r_regs[2*j]};
        end
    end

endmodule

/* sv/mpbs_lane.sv */
module mpbs_lane #(
    parameter int PATTERN_BYTES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mpbs_pkg::t_lane_ctl                i_ctl,
    input  logic [mpbs_pkg::BYTE_W-1:0]        i_data_byte,
    input  logic [mpbs_pkg::PATTERN_W-1:0]     i_pattern,
    output logic                               o_found
);

    logic [mpbs_pkg::MAX_PATTERN_BYTES-1:0][mpbs_pkg::BYTE_W-1:0] pat_bytes;
    logic [mpbs_pkg::COUNT_W-1:0] r_count;
    logic [mpbs_pkg::COUNT_W-1:0] n_count;
    logic                         r_found;
    logic                         n_found;
    logic [mpbs_pkg::COUNT_W-1:0] pat_len;
    logic [mpbs_pkg::BYTE_W-1:0]  exp_byte;
    logic [mpbs_pkg::COUNT_W-1:0] step_count;

    assign pat_bytes = i_pattern;

    // length is the position of the first zero byte
    always_comb begin
        pat_len = mpbs_pkg::COUNT_W'(PATTERN_BYTES);
        for (int k = PATTERN_BYTES - 1; k >= 0; k--) begin
            if (pat_bytes[k] == '0) begin
                pat_len = mpbs_pkg::COUNT_W'(k);
            end
        end
    end

    assign exp_byte = pat_bytes[r_count[mpbs_pkg::POS_W-1:0]];

    always_comb begin
        if (r_count < pat_len && i_data_byte == exp_byte) begin
            step_count = r_count + mpbs_pkg::COUNT_W'(1);
        end else if (i_data_byte == pat_bytes[0]) begin
            step_count = mpbs_pkg::COUNT_W'(1);
        end else begin
            step_count = '0;
        end
    end

    // empty or already found patterns hold their state
    always_comb begin
        if (pat_len == '0 || r_found) begin
            n_count = r_count;
            n_found = r_found;
        end else begin
            n_count = step_count;
            n_found = (step_count == pat_len);
        end
    end

    assign o_found = n_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_found <= 1'b0;
        end else if (i_ctl.advance) begin
            if (i_ctl.last) begin
                r_count <= '0;
                r_found <= 1'b0;
            end else begin
                r_count <= n_count;
                r_found <= n_found;
            end
        end
    end

endmodule

/* sv/multi_pattern_byte_scanner_core.sv */
// multi-pattern byte scanner
// input channel: one transaction per scanned byte (data_byte, last_byte) on
// i_in_valid / o_in_ready. output channel: one transaction per input byte on
// o_out_valid / i_out_ready carrying found_mask (sticky per pattern, including
// the current byte) and scan_done (copy of last_byte).
// patterns live in eight 64-bit registers written through i_cfg_we /
// i_cfg_idx / i_cfg_data, two per pattern; a pattern ends at its first zero
// byte and an empty pattern is never reported. write them only while idle.
// each accepted byte passes through the input register, then the result
// register, from which its result is taken. throughput: one byte per cycle
// while the receiver does not stall, set by the single compare-and-update
// step of the per-pattern match counters.
// when the receiver stalls, the result register holds and the input register
// still takes one more byte; after that o_in_ready drops until the result
// drains. reset clears pattern registers, counts, found flags and both
// pipeline valid flags. after a byte marked last, counts and flags are cleared.
module multi_pattern_byte_scanner_core #(
    parameter int ACTIVE_PATTERNS = 4,
    parameter int PATTERN_BYTES   = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  mpbs_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output mpbs_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_we,
    input  logic [mpbs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mpbs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    mpbs_pkg::t_patterns               patterns;
    mpbs_pkg::t_lane_ctl               lane_ctl;
    logic [mpbs_pkg::MAX_PATTERNS-1:0] found_next;

    logic           r_in_valid;
    mpbs_pkg::t_in  r_in;
    logic           r_out_valid;
    mpbs_pkg::t_out r_out;
    logic           advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign lane_ctl.advance = advance;
    assign lane_ctl.last    = r_in.last_byte;

    mpbs_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_patterns (patterns)
    );

    for (genvar j = 0; j < mpbs_pkg::MAX_PATTERNS; j++) begin : g_lane
        if (j < ACTIVE_PATTERNS) begin : g_on
            mpbs_lane #(
                .PATTERN_BYTES (PATTERN_BYTES)
            ) u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (lane_ctl),
                .i_data_byte (r_in.data_byte),
                .i_pattern   (patterns[j]),
                .o_found     (found_next[j])
            );
        end else begin : g_off
            assign found_next[j] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.found_mask <= found_next;
            r_out.scan_done  <= r_in.last_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
